// ----- sv/prc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions for the Planck raw-to-Celsius converter
// Field widths, register indexes, status codes, fixed constants and the
// per-item flag word that travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int CFG_W     = 32;
   localparam int RAW_W     = 16;
   localparam int TEMP_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   // Signed count value raw*2^16 + O and its magnitude.
   localparam int S_W    = 34;
   localparam int SMAG_W = 33;

   // First division: R1*2^60 / (R2*|s|).
   localparam int NUM1_W = 92;
   localparam int DEN1_W = 65;
   localparam int QUO1_W = 64;

   // Logarithm argument and result.
   localparam int ARG_W         = 64;
   localparam int LOG_W         = 64;
   localparam int LOG_FRAC_BITS = 56;

   // Second division: B*2^56 / ln.
   localparam int NUM2_W = 88;
   localparam int DEN2_W = 64;
   localparam int QUO2_W = 40;

   // Temperature before clamping.
   localparam int T_W = 42;

   localparam logic [CFG_W-1:0] F_RESET        = 32'h0100_0000;
   localparam logic [LOG_W-1:0] LN2_Q64        = 64'hB172_17F7_D1CF_79AC;
   localparam logic [T_W-1:0]   CELSIUS_OFFSET = 42'd17901158;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_R1 = 3'd0,
      CSR_R2 = 3'd1,
      CSR_B  = 3'd2,
      CSR_F  = 3'd3,
      CSR_O  = 3'd4
   } prc_csr_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_DEN   = 2'd1,
      STATUS_LOG_NONPOS = 2'd2,
      STATUS_SAT        = 2'd3
   } prc_status_type;

   typedef struct packed {
      logic zden;
      logic neg;
      logic sat;
      logic nolog;
      logic pos;
      logic lzero;
   } prc_flags_type;

   localparam int FLAGS_W = $bits(prc_flags_type);

endpackage

// ----- sv/prc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_req_if / prc_rsp_if: item channels of the converter
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface prc_req_if;
   logic                         valid;
   logic                         ready;
   logic [prc_pkg::RAW_W-1:0]    raw_count;

   modport source (output valid, output raw_count, input ready);
   modport sink   (input valid, input raw_count, output ready);
endinterface

interface prc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [prc_pkg::TEMP_W-1:0] temp_celsius;
   logic [prc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output temp_celsius, output status, input ready);
   modport sink   (input valid, input temp_celsius, input status, output ready);
endinterface

// ----- sv/prc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_divider: pipelined restoring divider
// One quotient bit per stage. The caller must hold the numerator static (not
// enforced here); quotient bits above QUO_W only raise an overflow flag.
// ----------------------------------------------------------------------------
module prc_divider #(
   parameter int NUM_W  = prc_pkg::NUM1_W,
   parameter int DEN_W  = prc_pkg::DEN1_W,
   parameter int QUO_W  = prc_pkg::QUO1_W,
   parameter int SIDE_W = prc_pkg::FLAGS_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [NUM_W-1:0]  num,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [1:NUM_W];
   logic [DEN_W-1:0]  rem_ff   [1:NUM_W];
   logic [DEN_W-1:0]  den_ff   [1:NUM_W];
   logic [QUO_W-1:0]  quo_ff   [1:NUM_W];
   logic              ovf_ff   [1:NUM_W];
   logic [SIDE_W-1:0] side_ff  [1:NUM_W];

   for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
      logic              prev_valid;
      logic [DEN_W-1:0]  prev_rem;
      logic [DEN_W-1:0]  prev_den;
      logic [QUO_W-1:0]  prev_quo;
      logic              prev_ovf;
      logic [SIDE_W-1:0] prev_side;
      logic [DEN_W:0]    shifted;
      logic [DEN_W:0]    diff;
      logic              take;

      if (k == 1) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_den   = in_den;
         assign prev_quo   = '0;
         assign prev_ovf   = 1'b0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_ovf   = ovf_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      assign shifted = {prev_rem, num[NUM_W-k]};
      assign diff    = shifted - {1'b0, prev_den};
      assign take    = (shifted >= {1'b0, prev_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            den_ff[k]  <= prev_den;
            side_ff[k] <= prev_side;
         end
      end

      if (NUM_W - k >= QUO_W) begin : g_high
         always_ff @(posedge clock) begin
            if (enable) begin
               quo_ff[k] <= prev_quo;
               ovf_ff[k] <= prev_ovf | take;
            end
         end
      end else begin : g_low
         if (QUO_W > 1) begin : g_wide
            always_ff @(posedge clock) begin
               if (enable) begin
                  quo_ff[k] <= {prev_quo[QUO_W-2:0], take};
                  ovf_ff[k] <= prev_ovf;
               end
            end
         end else begin : g_single
            always_ff @(posedge clock) begin
               if (enable) begin
                  quo_ff[k] <= take;
                  ovf_ff[k] <= prev_ovf;
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quo   = quo_ff[NUM_W];
   assign out_ovf   = ovf_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule

// ----- sv/prc_log2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_log2: pipelined base-2 logarithm
// Leading-one encode, normalize, then one fraction bit per squaring step;
// each squaring takes a partial-product stage and a summing stage.
// ----------------------------------------------------------------------------
module prc_log2 #(
   parameter int SIDE_W = prc_pkg::FLAGS_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [prc_pkg::ARG_W-1:0]  in_arg,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [prc_pkg::LOG_W-1:0]  out_lg,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int AW    = prc_pkg::ARG_W;
   localparam int HW    = AW / 2;
   localparam int PW    = $clog2(AW);
   localparam int FRAC  = prc_pkg::LOG_FRAC_BITS;
   localparam int INT_W = prc_pkg::LOG_W - FRAC;

   // Encode stage.
   logic              enc_valid_ff;
   logic [AW-1:0]     enc_arg_ff;
   logic [PW-1:0]     enc_p_ff;
   logic [SIDE_W-1:0] enc_side_ff;
   logic [PW-1:0]     enc_p_in;

   // Normalize stage.
   logic              nrm_valid_ff;
   logic [AW-1:0]     nrm_m_ff;
   logic [PW-1:0]     nrm_p_ff;
   logic [SIDE_W-1:0] nrm_side_ff;

   // Squaring steps: A holds partial products, B the new mantissa.
   logic              a_valid_ff [1:FRAC];
   logic [AW-1:0]     a_p00_ff   [1:FRAC];
   logic [AW-1:0]     a_p01_ff   [1:FRAC];
   logic [AW-1:0]     a_p11_ff   [1:FRAC];
   logic [FRAC-1:0]   a_frac_ff  [1:FRAC];
   logic [PW-1:0]     a_p_ff     [1:FRAC];
   logic [SIDE_W-1:0] a_side_ff  [1:FRAC];

   logic              b_valid_ff [1:FRAC];
   logic [AW-1:0]     b_m_ff     [1:FRAC];
   logic [FRAC-1:0]   b_frac_ff  [1:FRAC];
   logic [PW-1:0]     b_p_ff     [1:FRAC];
   logic [SIDE_W-1:0] b_side_ff  [1:FRAC];

   logic [INT_W-1:0]  int_part;

   always_comb begin
      enc_p_in = '0;
      for (int b = 0; b < AW; b++) begin
         if (in_arg[b]) begin
            enc_p_in = PW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_valid_ff <= 1'b0;
         nrm_valid_ff <= 1'b0;
      end else if (enable) begin
         enc_valid_ff <= in_valid;
         nrm_valid_ff <= enc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         enc_arg_ff  <= in_arg;
         enc_p_ff    <= enc_p_in;
         enc_side_ff <= in_side;
         nrm_m_ff    <= enc_arg_ff << (~enc_p_ff);
         nrm_p_ff    <= enc_p_ff;
         nrm_side_ff <= enc_side_ff;
      end
   end

   for (genvar i = 1; i <= FRAC; i++) begin : g_step
      logic              prev_valid;
      logic [AW-1:0]     prev_m;
      logic [FRAC-1:0]   prev_frac;
      logic [PW-1:0]     prev_p;
      logic [SIDE_W-1:0] prev_side;
      logic [2*AW-1:0]   sq;

      if (i == 1) begin : g_first
         assign prev_valid = nrm_valid_ff;
         assign prev_m     = nrm_m_ff;
         assign prev_frac  = '0;
         assign prev_p     = nrm_p_ff;
         assign prev_side  = nrm_side_ff;
      end else begin : g_next
         assign prev_valid = b_valid_ff[i-1];
         assign prev_m     = b_m_ff[i-1];
         assign prev_frac  = b_frac_ff[i-1];
         assign prev_p     = b_p_ff[i-1];
         assign prev_side  = b_side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[i] <= 1'b0;
            b_valid_ff[i] <= 1'b0;
         end else if (enable) begin
            a_valid_ff[i] <= prev_valid;
            b_valid_ff[i] <= a_valid_ff[i];
         end
      end

      // Square of m = a1*2^32 + a0 from the three distinct partial products.
      assign sq = {a_p11_ff[i], a_p00_ff[i]} + ({{AW{1'b0}}, a_p01_ff[i]} << (HW + 1));

      always_ff @(posedge clock) begin
         if (enable) begin
            a_p00_ff[i]  <= AW'(prev_m[HW-1:0]) * AW'(prev_m[HW-1:0]);
            a_p01_ff[i]  <= AW'(prev_m[HW-1:0]) * AW'(prev_m[AW-1:HW]);
            a_p11_ff[i]  <= AW'(prev_m[AW-1:HW]) * AW'(prev_m[AW-1:HW]);
            a_frac_ff[i] <= prev_frac;
            a_p_ff[i]    <= prev_p;
            a_side_ff[i] <= prev_side;

            b_m_ff[i]    <= sq[2*AW-1] ? sq[2*AW-1:AW] : sq[2*AW-2:AW-1];
            b_frac_ff[i] <= {a_frac_ff[i][FRAC-2:0], sq[2*AW-1]};
            b_p_ff[i]    <= a_p_ff[i];
            b_side_ff[i] <= a_side_ff[i];
         end
      end
   end

   // Integer part is the leading-one position less the 32 fraction bits of
   // the argument, in two's complement above the fraction.
   assign int_part  = INT_W'(b_p_ff[FRAC]) - INT_W'(HW);
   assign out_valid = b_valid_ff[FRAC];
   assign out_lg    = {int_part, b_frac_ff[FRAC]};
   assign out_side  = b_side_ff[FRAC];

endmodule

// ----- sv/planck_raw_to_celsius.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planck_raw_to_celsius: raw radiometric count to Celsius converter
// Evaluates T = B / ln(R1 / (R2*(raw+O)) + F) - 273.15 in fixed point.
// ----------------------------------------------------------------------------
// Each accepted item is one 16-bit raw pixel count; each result item carries
// the temperature in signed Q16.16 degrees Celsius and a 2-bit status. The
// block takes a new item on every clock while the result side does not stall;
// most of its depth lies in the two restoring dividers (92 and 88 stages, one
// quotient bit each) and in the logarithm, which spends two stages on each
// of its 56 squaring steps. The whole pipeline advances together; a stage
// after the last pipeline register (a skid entry) lets one more item drain
// out while a result waits to be taken, so a stalled output costs no item
// and repeats none.
// Configuration is written through csr_we/csr_index/csr_wdata and must only
// change while no item is in flight; indexes past the offset register are
// ignored.
// ----------------------------------------------------------------------------
module planck_raw_to_celsius (
   input  logic                           clock,
   input  logic                           reset,
   prc_req_if.sink                        req,
   prc_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [prc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prc_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int CW = prc_pkg::CFG_W;
   localparam int TW = prc_pkg::TEMP_W;

   // Configuration registers.
   logic [CW-1:0] r1_ff, r2_ff, b_ff, f_ff, o_ff;

   // Global advance: the pipeline moves unless the skid entry is occupied.
   logic advance;

   // Stage 1: input register.
   logic                       v1_ff;
   logic [prc_pkg::RAW_W-1:0]  raw_ff;
   // Stage 2: signed count raw*2^16 + O.
   logic                       v2_ff;
   logic signed [prc_pkg::S_W-1:0] s_ff;
   logic signed [prc_pkg::S_W-1:0] s_in;
   // Stage 3: magnitude and special flags.
   logic                       v3_ff;
   logic [prc_pkg::SMAG_W-1:0] smag_ff;
   logic [prc_pkg::S_W-1:0]    sabs;
   prc_pkg::prc_flags_type     fl3_ff, fl3_in;
   // Stage 4: denominator R2*|s|.
   logic                       v4_ff;
   logic [prc_pkg::DEN1_W-1:0] den_ff;
   prc_pkg::prc_flags_type     fl4_ff;

   // First divider.
   logic                       d1_valid;
   logic [prc_pkg::QUO1_W-1:0] d1_quo;
   logic                       d1_ovf;
   prc_pkg::prc_flags_type     d1_flags;

   // Stage 5: log argument.
   logic                       v5_ff;
   logic [prc_pkg::ARG_W-1:0]  arg_ff, arg_in;
   prc_pkg::prc_flags_type     fl5_ff, fl5_in;
   logic [prc_pkg::ARG_W-1:0]  fq;
   logic [prc_pkg::ARG_W:0]    arg_sum;

   // Logarithm.
   logic                       lg_valid;
   logic [prc_pkg::LOG_W-1:0]  lg;
   prc_pkg::prc_flags_type     lg_flags;

   // Stage 6: |log2| and its sign.
   logic                       v6_ff;
   logic [prc_pkg::LOG_W-1:0]  mag_ff;
   prc_pkg::prc_flags_type     fl6_ff, fl6_in;
   // Stage 7: partial products of |log2| * ln(2).
   logic                       v7_ff;
   logic [prc_pkg::LOG_W-1:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   prc_pkg::prc_flags_type     fl7_ff;
   // Stage 8: natural log magnitude.
   logic                       v8_ff;
   logic [prc_pkg::DEN2_W-1:0] lmag_ff;
   prc_pkg::prc_flags_type     fl8_ff, fl8_in;
   logic [2*prc_pkg::LOG_W-1:0] ln_full;

   // Second divider.
   logic                       d2_valid;
   logic [prc_pkg::QUO2_W-1:0] d2_quo;
   logic                       d2_ovf;
   prc_pkg::prc_flags_type     d2_flags;

   // Stage 9: signed Celsius before clamping.
   logic                       v9_ff;
   logic signed [prc_pkg::T_W-1:0] t_ff, t_in;
   logic                       kovf_ff;
   prc_pkg::prc_flags_type     fl9_ff;
   // Stage 10: final result.
   logic                       v10_ff;
   logic [TW-1:0]              res_temp_ff, res_temp_in;
   logic [prc_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   // Output register and skid entry.
   logic                       out_v_ff, skid_v_ff;
   logic [TW-1:0]              out_temp_ff, skid_temp_ff;
   logic [prc_pkg::STATUS_W-1:0] out_status_ff, skid_status_ff;
   logic                       out_take;
   logic                       push;

   localparam logic signed [prc_pkg::T_W-1:0] T_MAX = prc_pkg::T_W'({1'b0, {(TW-1){1'b1}}});
   localparam logic signed [prc_pkg::T_W-1:0] T_MIN = -T_MAX - prc_pkg::T_W'(1);
   localparam logic [TW-1:0] TEMP_MAX = {1'b0, {(TW-1){1'b1}}};
   localparam logic [TW-1:0] TEMP_MIN = {1'b1, {(TW-1){1'b0}}};

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff <= '0;
         r2_ff <= '0;
         b_ff  <= '0;
         f_ff  <= prc_pkg::F_RESET;
         o_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            prc_pkg::CSR_R1: r1_ff <= csr_wdata;
            prc_pkg::CSR_R2: r2_ff <= csr_wdata;
            prc_pkg::CSR_B:  b_ff  <= csr_wdata;
            prc_pkg::CSR_F:  f_ff  <= csr_wdata;
            prc_pkg::CSR_O:  o_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = !skid_v_ff;
   assign req.ready = advance;

   // ------------------------------------------------------ front stages 1-4
   assign s_in = $signed({2'b00, raw_ff, 16'h0000}) + prc_pkg::S_W'($signed(o_ff));
   assign sabs = s_ff[prc_pkg::S_W-1] ? prc_pkg::S_W'(-s_ff) : prc_pkg::S_W'(s_ff);

   always_comb begin
      fl3_in      = '0;
      fl3_in.zden = (r2_ff == '0) || (s_ff == '0);
      fl3_in.neg  = s_ff[prc_pkg::S_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff  <= req.raw_count;
         s_ff    <= s_in;
         smag_ff <= sabs[prc_pkg::SMAG_W-1:0];
         fl3_ff  <= fl3_in;
         den_ff  <= prc_pkg::DEN1_W'(r2_ff) * prc_pkg::DEN1_W'(smag_ff);
         fl4_ff  <= fl3_ff;
      end
   end

   // R1/denominator as unsigned Q32.32; quotient bits above 64 mean overflow.
   prc_divider #(
      .NUM_W  (prc_pkg::NUM1_W),
      .DEN_W  (prc_pkg::DEN1_W),
      .QUO_W  (prc_pkg::QUO1_W),
      .SIDE_W (prc_pkg::FLAGS_W)
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .num       ({r1_ff, {(prc_pkg::NUM1_W - CW){1'b0}}}),
      .in_valid  (v4_ff),
      .in_den    (den_ff),
      .in_side   (fl4_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_ovf   (d1_ovf),
      .out_side  (d1_flags)
   );

   // --------------------------------------------------- stage 5: log argument
   // F moves from Q8.24 to Q32.32. A positive count adds the ratio and
   // saturates on overflow; a negative count subtracts it, and a result that
   // would not be positive ends the item with the log-argument status.
   assign fq      = {{(prc_pkg::ARG_W - CW - 8){1'b0}}, f_ff, 8'h00};
   assign arg_sum = {1'b0, d1_quo} + {1'b0, fq};

   always_comb begin
      fl5_in = d1_flags;
      arg_in = fq - d1_quo;
      if (!d1_flags.neg) begin
         if (d1_ovf || arg_sum[prc_pkg::ARG_W]) begin
            arg_in     = '1;
            fl5_in.sat = 1'b1;
         end else begin
            arg_in = arg_sum[prc_pkg::ARG_W-1:0];
         end
      end else if (d1_ovf || (d1_quo >= fq)) begin
         fl5_in.nolog = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         arg_ff <= arg_in;
         fl5_ff <= fl5_in;
      end
   end

   prc_log2 #(
      .SIDE_W (prc_pkg::FLAGS_W)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (v5_ff),
      .in_arg    (arg_ff),
      .in_side   (fl5_ff),
      .out_valid (lg_valid),
      .out_lg    (lg),
      .out_side  (lg_flags)
   );

   // ------------------------------------------- stages 6-8: ln = log2 * ln(2)
   always_comb begin
      fl6_in     = lg_flags;
      fl6_in.pos = !lg[prc_pkg::LOG_W-1] && (lg != '0);
   end

   assign ln_full = {pp11_ff, pp00_ff}
                  + ({{prc_pkg::LOG_W{1'b0}}, pp01_ff} << (prc_pkg::LOG_W / 2))
                  + ({{prc_pkg::LOG_W{1'b0}}, pp10_ff} << (prc_pkg::LOG_W / 2));

   always_comb begin
      fl8_in       = fl7_ff;
      fl8_in.lzero = (ln_full[2*prc_pkg::LOG_W-1:prc_pkg::LOG_W] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= lg_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff  <= lg[prc_pkg::LOG_W-1] ? -lg : lg;
         fl6_ff  <= fl6_in;
         pp00_ff <= prc_pkg::LOG_W'(mag_ff[31:0])  * prc_pkg::LOG_W'(prc_pkg::LN2_Q64[31:0]);
         pp01_ff <= prc_pkg::LOG_W'(mag_ff[31:0])  * prc_pkg::LOG_W'(prc_pkg::LN2_Q64[63:32]);
         pp10_ff <= prc_pkg::LOG_W'(mag_ff[63:32]) * prc_pkg::LOG_W'(prc_pkg::LN2_Q64[31:0]);
         pp11_ff <= prc_pkg::LOG_W'(mag_ff[63:32]) * prc_pkg::LOG_W'(prc_pkg::LN2_Q64[63:32]);
         fl7_ff  <= fl6_ff;
         lmag_ff <= ln_full[2*prc_pkg::LOG_W-1:prc_pkg::LOG_W];
         fl8_ff  <= fl8_in;
      end
   end

   // Kelvin magnitude in Q16.16; anything at or above 2^40 saturates.
   prc_divider #(
      .NUM_W  (prc_pkg::NUM2_W),
      .DEN_W  (prc_pkg::DEN2_W),
      .QUO_W  (prc_pkg::QUO2_W),
      .SIDE_W (prc_pkg::FLAGS_W)
   ) u_div_kelvin (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .num       ({b_ff, {(prc_pkg::NUM2_W - CW){1'b0}}}),
      .in_valid  (v8_ff),
      .in_den    (lmag_ff),
      .in_side   (fl8_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_ovf   (d2_ovf),
      .out_side  (d2_flags)
   );

   // ------------------------------------------ stages 9-10: Celsius and clamp
   assign t_in = (d2_flags.pos ? $signed({2'b00, d2_quo}) : -$signed({2'b00, d2_quo}))
               - $signed(prc_pkg::CELSIUS_OFFSET);

   // Special outcomes take priority in the order the formula reaches them.
   always_comb begin
      res_temp_in   = t_ff[TW-1:0];
      res_status_in = fl9_ff.sat ? prc_pkg::STATUS_SAT : prc_pkg::STATUS_OK;
      if (fl9_ff.zden) begin
         res_temp_in   = '0;
         res_status_in = prc_pkg::STATUS_ZERO_DEN;
      end else if (fl9_ff.nolog) begin
         res_temp_in   = '0;
         res_status_in = prc_pkg::STATUS_LOG_NONPOS;
      end else if (fl9_ff.lzero) begin
         res_temp_in   = TEMP_MAX;
         res_status_in = prc_pkg::STATUS_SAT;
      end else if (kovf_ff) begin
         res_temp_in   = fl9_ff.pos ? TEMP_MAX : TEMP_MIN;
         res_status_in = prc_pkg::STATUS_SAT;
      end else if (t_ff > T_MAX) begin
         res_temp_in   = TEMP_MAX;
         res_status_in = prc_pkg::STATUS_SAT;
      end else if (t_ff < T_MIN) begin
         res_temp_in   = TEMP_MIN;
         res_status_in = prc_pkg::STATUS_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (advance) begin
         v9_ff  <= d2_valid;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff          <= t_in;
         kovf_ff       <= d2_ovf;
         fl9_ff        <= d2_flags;
         res_temp_ff   <= res_temp_in;
         res_status_ff <= res_status_in;
      end
   end

   // ------------------------------------------------- output and skid entry
   // The last pipeline stage pushes into the output register when it is free
   // or being taken, otherwise into the skid entry, which then holds the
   // pipeline until the output drains.
   assign out_take = rsp.ready || !out_v_ff;
   assign push     = advance && v10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (out_take) begin
            out_v_ff <= skid_v_ff || push;
         end
         if (skid_v_ff && out_take) begin
            skid_v_ff <= 1'b0;
         end else if (push && !out_take) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_v_ff) begin
            out_temp_ff   <= skid_temp_ff;
            out_status_ff <= skid_status_ff;
         end else begin
            out_temp_ff   <= res_temp_ff;
            out_status_ff <= res_status_ff;
         end
      end
      if (push && !out_take) begin
         skid_temp_ff   <= res_temp_ff;
         skid_status_ff <= res_status_ff;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.temp_celsius = out_temp_ff;
   assign rsp.status       = out_status_ff;

   // ------------------------------------------------------------ assertions
   // The skid entry only fills behind a result that is still waiting.
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds an item while the output register is empty");

   // A zero denominator always reports a zero temperature.
   a_zero_den_temp : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == prc_pkg::STATUS_ZERO_DEN) |-> rsp.temp_celsius == '0)
      else $error("zero-denominator item carries a nonzero temperature");

   // A non-positive log argument always reports a zero temperature.
   a_nolog_temp : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == prc_pkg::STATUS_LOG_NONPOS) |-> rsp.temp_celsius == '0)
      else $error("log-argument item carries a nonzero temperature");

   // With the skid entry occupied, no new item may enter the pipeline.
   a_hold_when_full : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp.ready) |=> $stable(v1_ff) && skid_v_ff)
      else $error("pipeline advanced while the skid entry was full");

endmodule

// ----- bench/planck_raw_to_celsius_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planck_raw_to_celsius_tb: self-checking bench for the Planck converter
// Sends raw pixel counts under several sets of Planck constants, predicts
// each temperature and status in the bench, and checks every result item in
// order. It also covers random idling on both sides, a long output stall
// and configuration changes between phases.
// ----------------------------------------------------------------------------
module planck_raw_to_celsius_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 320;

   typedef struct {
      logic signed [prc_pkg::TEMP_W-1:0] temp;
      prc_pkg::prc_status_type           status;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [prc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [prc_pkg::CFG_W-1:0] csr_wdata = '0;

   prc_req_if req_ch ();
   prc_rsp_if rsp_ch ();

   // Shadow copies of the Planck constants, updated when a write is taken.
   logic [prc_pkg::CFG_W-1:0] cfg_r1, cfg_r2, cfg_b, cfg_f, cfg_o;

   pixel_result_type pending_temps[$];
   int  errors = 0;
   int  pixels_sent = 0;
   int  pixels_checked = 0;
   int  config_sets = 0;
   int  cycle_count = 0;
   int  out_hold_cycles = 0;
   bit  steady_flow = 1'b0;

   always #5 clock = ~clock;

   planck_raw_to_celsius u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.raw_count = '0;
      rsp_ch.ready = 1'b0;
   end

   // Predicts one conversion with the current shadow constants. The
   // arithmetic is exact: 128-bit products and quotients, then the log2 by
   // repeated squaring of a normalized mantissa.
   function automatic void predict_celsius(input logic [prc_pkg::RAW_W-1:0] raw,
                                           output pixel_result_type res);
      longint      s, lg, t, v;
      logic [63:0]  smag, q, fq, arg, m, frac, mag, lmag;
      logic [127:0] num, den, quo, sq;
      int          p;
      bit          sat, pos;
      sat = 1'b0;
      s = longint'(raw) * 65536 + longint'($signed(cfg_o));
      if (cfg_r2 == 0 || s == 0) begin
         res.temp = '0;
         res.status = prc_pkg::STATUS_ZERO_DEN;
         return;
      end
      smag = (s < 0) ? -s : s;
      den = 128'(cfg_r2) * 128'(smag);
      num = 128'(cfg_r1) << 60;
      quo = num / den;
      if (quo[127:64] != 0) begin
         q = '1;
         sat = 1'b1;
      end else begin
         q = quo[63:0];
      end
      fq = 64'(cfg_f) << 8;
      if (s > 0) begin
         if (q > ~fq) begin
            arg = '1;
            sat = 1'b1;
         end else begin
            arg = fq + q;
         end
      end else begin
         if (q >= fq) begin
            res.temp = '0;
            res.status = prc_pkg::STATUS_LOG_NONPOS;
            return;
         end
         arg = fq - q;
      end
      p = 63;
      while (p > 0 && !arg[p]) p--;
      m = arg << (63 - p);
      frac = '0;
      for (int i = 1; i <= prc_pkg::LOG_FRAC_BITS; i++) begin
         sq = 128'(m) * 128'(m);
         if (sq[127]) begin
            m = sq[127:64];
            frac[prc_pkg::LOG_FRAC_BITS-i] = 1'b1;
         end else begin
            m = sq[126:63];
         end
      end
      lg = longint'(p - 32) * (longint'(1) << prc_pkg::LOG_FRAC_BITS) + longint'(frac);
      pos = lg > 0;
      mag = (lg < 0) ? -lg : lg;
      sq = 128'(mag) * 128'(prc_pkg::LN2_Q64);
      lmag = sq[127:64];
      if (lmag == 0) begin
         res.temp = 32'h7FFF_FFFF;
         res.status = prc_pkg::STATUS_SAT;
         return;
      end
      num = 128'(cfg_b) << 56;
      quo = num / 128'(lmag);
      if (quo >= (128'd1 << prc_pkg::QUO2_W)) begin
         res.temp = pos ? 32'h7FFF_FFFF : 32'h8000_0000;
         sat = 1'b1;
      end else begin
         v = longint'(quo[prc_pkg::QUO2_W-1:0]);
         t = (pos ? v : -v) - longint'(prc_pkg::CELSIUS_OFFSET);
         if (t > 64'sh7FFF_FFFF) begin
            t = 64'sh7FFF_FFFF;
            sat = 1'b1;
         end
         if (t < -64'sh8000_0000) begin
            t = -64'sh8000_0000;
            sat = 1'b1;
         end
         res.temp = t[31:0];
      end
      res.status = sat ? prc_pkg::STATUS_SAT : prc_pkg::STATUS_OK;
   endfunction

   // Sends one pixel, with a random idle gap first unless steady flow is set, and
   // records its expected result once the block has taken it.
   task automatic send_pixel(input logic [prc_pkg::RAW_W-1:0] raw);
      pixel_result_type res;
      while (!steady_flow && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_count <= raw;
      do @(posedge clock); while (!req_ch.ready);
      predict_celsius(raw, res);
      pending_temps.insert(pending_temps.size(), res);
      pixels_sent++;
   endtask

   task automatic end_burst();
      req_ch.valid <= 1'b0;
      while (pending_temps.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Writes one register; the caller lowers csr_we after the last write.
   task automatic write_reg(input logic [prc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [prc_pkg::CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         prc_pkg::CSR_R1: cfg_r1 = val;
         prc_pkg::CSR_R2: cfg_r2 = val;
         prc_pkg::CSR_B:  cfg_b = val;
         prc_pkg::CSR_F:  cfg_f = val;
         prc_pkg::CSR_O:  cfg_o = val;
         default: ;
      endcase
   endtask

   task automatic load_constants(input logic [prc_pkg::CFG_W-1:0] r1, r2, b, f, o);
      end_burst();
      write_reg(prc_pkg::CSR_R1, r1);
      write_reg(prc_pkg::CSR_R2, r2);
      write_reg(prc_pkg::CSR_B, b);
      write_reg(prc_pkg::CSR_F, f);
      write_reg(prc_pkg::CSR_O, o);
      csr_we <= 1'b0;
      @(posedge clock);
      config_sets++;
   endtask

   // Typical camera constants, each optionally nudged at random.
   task automatic load_typical(input bit jitter);
      logic [prc_pkg::CFG_W-1:0] r1, r2, b, o;
      r1 = 32'd17000 << 16;
      r2 = 32'd3355443;
      b = 32'd1430 << 16;
      o = -(32'd7000 << 16);
      if (jitter) begin
         r1 = r1 + $urandom_range(32'h00FF_FFFF) - 32'h007F_FFFF;
         r2 = r2 + $urandom_range(32'h000F_FFFF) - 32'h0007_FFFF;
         b = b + $urandom_range(32'h01FF_FFFF) - 32'h00FF_FFFF;
         o = o + $urandom_range(32'h0FFF_FFFF) - 32'h07FF_FFFF;
      end
      load_constants(r1, r2, b,
                     prc_pkg::F_RESET + $urandom_range(jitter ? 32'h00FF_FFFF : 0), o);
   endtask

   function automatic logic [prc_pkg::RAW_W-1:0] pick_raw();
      logic [prc_pkg::RAW_W-1:0] r;
      logic [prc_pkg::RAW_W-1:0] knee;
      // Counts near -O land close to the zero-denominator point.
      knee = prc_pkg::RAW_W'(-($signed(cfg_o) >>> 16));
      case ($urandom_range(9))
         0: r = prc_pkg::RAW_W'(int'(knee) + int'($urandom_range(4)) - 2);
         1: r = $urandom_range(1) ? '1 : '0;
         default: r = prc_pkg::RAW_W'($urandom());
      endcase
      return r;
   endfunction

   task automatic test_reset_values();
      // Constants still at reset: R2 is zero, so every pixel is a zero divide.
      send_pixel('0);
      send_pixel('1);
      send_pixel(16'h5A5A);
      end_burst();
   endtask

   task automatic test_directed();
      load_typical(1'b0);
      send_pixel('0);
      send_pixel('1);
      send_pixel(16'd7000);   // raw + O is exactly zero
      send_pixel(16'd6999);   // small negative count offset
      send_pixel(16'd7001);
      send_pixel(16'd20000);
      // R1 zero: the log argument is F = 1.0 exactly, so the log vanishes.
      load_constants('0, 32'd3355443, 32'd1430 << 16, prc_pkg::F_RESET, '0);
      send_pixel(16'd1);
      send_pixel(16'd30000);
      // F zero and O most negative: the zero count is negative, so its log argument cannot be positive.
      load_constants(32'd17000 << 16, 32'd3355443, 32'd1430 << 16, '0, 32'h8000_0000);
      send_pixel('0);
      send_pixel('1);
      // All constants at their largest: argument overflow and clamping.
      load_constants('1, '1, '1, '1, 32'h7FFF_FFFF);
      send_pixel('0);
      send_pixel('1);
      load_constants('1, 32'd1, '1, '0, 32'h8000_0000);
      send_pixel('0);
      send_pixel('1);
      send_pixel(16'h8000);
      // Zero B and tiny R2.
      load_constants(32'd1, 32'd1, '0, 32'd1, 32'd1);
      send_pixel('0);
      send_pixel(16'h0001);
      send_pixel('1);
      end_burst();
      // Writes past the last register must change nothing.
      for (int i = int'(prc_pkg::CSR_O) + 1; i < (1 << prc_pkg::CSR_IDX_W); i++)
         write_reg(prc_pkg::CSR_IDX_W'(i), '0);
      csr_we <= 1'b0;
      send_pixel(16'd12345);
      send_pixel(16'd40000);
      end_burst();
   endtask

   task automatic test_random_constants();
      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 3 == 2)
            load_constants($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         else
            load_typical(1'b1);
         for (int n = 0; n < 120; n++) send_pixel(pick_raw());
      end
      end_burst();
   endtask

   task automatic test_output_stall();
      load_typical(1'b1);
      // The result side holds off long enough for the pipeline to fill.
      out_hold_cycles = 700;
      for (int n = 0; n < 400; n++) send_pixel(pick_raw());
      // Pause until every result is back, then go on.
      end_burst();
      for (int n = 0; n < 50; n++) send_pixel(pick_raw());
      end_burst();
   endtask

   task automatic test_steady_flow();
      load_typical(1'b1);
      steady_flow = 1'b1;
      for (int n = 0; n < 250; n++) send_pixel(pick_raw());
      steady_flow = 1'b0;
      for (int n = 0; n < 100; n++) send_pixel(pick_raw());
      end_burst();
   endtask

   // Result side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (out_hold_cycles > 0) begin
         out_hold_cycles <= out_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 23);
      end
   end

   // Each result item is compared with the oldest expected one.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_temps.size() == 0) begin
            $display("%0t: unexpected result item temp=%h status=%0d", $time,
                     rsp_ch.temp_celsius, rsp_ch.status);
            errors++;
         end else begin
            want = pending_temps.pop_front();
            pixels_checked++;
            if (rsp_ch.temp_celsius !== want.temp) begin
               $display("%0t: temp_celsius expected %h actual %h", $time,
                        want.temp, rsp_ch.temp_celsius);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_ch.status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      cfg_r1 = '0;
      cfg_r2 = '0;
      cfg_b = '0;
      cfg_f = prc_pkg::F_RESET;
      cfg_o = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed();
      test_random_constants();
      test_output_stall();
      test_steady_flow();

      end_burst();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d pixels, %0d results checked, across %0d constant sets.",
               pixels_sent, pixels_checked, config_sets);
      $display("Covered zero divides, non-positive log arguments, saturation and stalls.");
      if (errors == 0 && pending_temps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
